// ----- rtl/core/lru_key_value_cache_macros.svh -----
// Assertion macros for the LRU key-value cache.
// Uses the clk and rst_n of the module that includes it.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

`ifndef SYNTHESIS
`define LKV_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lkv assertion failed");
`define LKV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lkv assertion failed");
`else
`define LKV_ASSERT_IMPL(lbl, ante, cons)
`define LKV_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/lkv_pkg.sv -----
// Types and constants shared by the LRU key-value cache.
// No dependencies.
package lkv_pkg;

  localparam logic       KIND_GET   = 1'b0;
  localparam logic       KIND_PUT   = 1'b1;
  localparam logic [4:0] CAP_RESET  = 5'd16;
  localparam logic signed [31:0] MISS_VALUE = 32'shFFFFFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_ACT,
    ST_DROP,
    ST_APPEND
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_PROMOTE,
    CELL_DROP,
    CELL_APPEND
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] bus_key;
    logic signed [31:0] bus_value;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/lkv_cell.sv -----
// One slot of the recency chain: key, value, valid mark and match flag.
// Depends on lkv_pkg.
module lkv_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  lkv_pkg::cell_ctrl_t ctrl,
  input  logic signed [31:0] up_key,
  input  logic signed [31:0] up_value,
  input  logic               up_valid,
  input  logic               lo_valid,
  input  logic               pfx_in,
  output logic signed [31:0] slot_key,
  output logic signed [31:0] slot_value,
  output logic               slot_valid,
  output logic               match,
  output logic               pfx_out
);

  logic signed [31:0] key_r, key_nxt;
  logic signed [31:0] value_r, value_nxt;
  logic               valid_r, valid_nxt;
  logic               match_r, match_nxt;
  logic               sel;

  always_comb begin
    key_nxt   = key_r;
    value_nxt = value_r;
    valid_nxt = valid_r;
    match_nxt = match_r;
    sel       = pfx_in | match_r;
    case (ctrl.op)
      lkv_pkg::CELL_CMP: begin
        match_nxt = valid_r && (key_r == ctrl.bus_key);
      end
      lkv_pkg::CELL_PROMOTE: begin
        // at or above the hit slot: pull from above, the newest slot takes the bus
        if (sel) begin
          if (up_valid) begin
            key_nxt   = up_key;
            value_nxt = up_value;
          end else if (valid_r) begin
            key_nxt   = ctrl.bus_key;
            value_nxt = ctrl.bus_value;
          end
        end
      end
      lkv_pkg::CELL_DROP: begin
        key_nxt   = up_key;
        value_nxt = up_value;
        valid_nxt = up_valid;
      end
      lkv_pkg::CELL_APPEND: begin
        if (!valid_r && lo_valid) begin
          key_nxt   = ctrl.bus_key;
          value_nxt = ctrl.bus_value;
          valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign slot_key   = key_r;
  assign slot_value = value_r;
  assign slot_valid = valid_r;
  assign match      = match_r;
  assign pfx_out    = sel;

endmodule

// ----- rtl/core/lru_key_value_cache.sv -----
// LRU key-value cache: a chain of slot cells, slot 0 least recent.
// Each beat is registered, compared in the compare state and applied in the act state,
// where a get loads its result into the output register and the next beat may be taken.
// A put miss on a full cache takes the drop state once per dropped entry, then appends.
// Reset clears all valid marks and the entry count at once; capacity resets to 16.
// Depends on lkv_pkg, lkv_cell and lru_key_value_cache_macros.svh.
`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic signed [31:0] in_key,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic signed [31:0] out_read_value
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = (CW > 5) ? CW : 5;

  lkv_pkg::state_t state_r, state_nxt;
  logic [4:0]         cap_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic               kind_r;
  logic signed [31:0] key_r, value_r;
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r;
  logic signed [31:0] out_read_value_r;

  logic [EW-1:0]      eff_cap;
  logic [EW-1:0]      count_ext;
  logic               room;
  logic               hit;
  logic               act_go;
  logic               finishing;
  logic               accept;
  logic               out_load;
  logic signed [31:0] sel_value;
  lkv_pkg::cell_ctrl_t ctrl;

  logic signed [31:0] cell_key   [MAX_ENTRIES];
  logic signed [31:0] cell_value [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_vec;
  logic [MAX_ENTRIES-1:0] match_vec;
  logic [MAX_ENTRIES-1:0] pfx_vec;

  // effective capacity: zero reads as one, saturate at the slot count
  always_comb begin
    if (cap_r == 5'd0) begin
      eff_cap = EW'(1);
    end else if (EW'(cap_r) > EW'(MAX_ENTRIES)) begin
      eff_cap = EW'(MAX_ENTRIES);
    end else begin
      eff_cap = EW'(cap_r);
    end
  end

  assign count_ext = EW'(count_r);
  assign room      = count_ext < eff_cap;
  assign hit       = |match_vec;
  assign act_go    = !(kind_r == lkv_pkg::KIND_GET && out_valid_r && out_stall);
  assign finishing = (kind_r == lkv_pkg::KIND_GET) || hit || room;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    sel_value = '0;
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      sel_value = sel_value | (match_vec[j] ? cell_value[j] : 32'sd0);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    in_stall      = 1'b1;
    out_load      = 1'b0;
    ctrl.op       = lkv_pkg::CELL_HOLD;
    ctrl.bus_key  = key_r;
    ctrl.bus_value = (kind_r == lkv_pkg::KIND_GET) ? sel_value : value_r;
    case (state_r)
      lkv_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = lkv_pkg::ST_CMP;
        end
      end
      lkv_pkg::ST_CMP: begin
        ctrl.op   = lkv_pkg::CELL_CMP;
        state_nxt = lkv_pkg::ST_ACT;
      end
      lkv_pkg::ST_ACT: begin
        if (act_go) begin
          if (kind_r == lkv_pkg::KIND_GET || hit) begin
            ctrl.op  = lkv_pkg::CELL_PROMOTE;
            out_load = (kind_r == lkv_pkg::KIND_GET);
          end else if (room) begin
            ctrl.op   = lkv_pkg::CELL_APPEND;
            count_nxt = count_r + CW'(1);
          end
          if (finishing) begin
            in_stall  = 1'b0;
            state_nxt = in_valid ? lkv_pkg::ST_CMP : lkv_pkg::ST_IDLE;
          end else begin
            state_nxt = lkv_pkg::ST_DROP;
          end
        end
      end
      lkv_pkg::ST_DROP: begin
        // shift the oldest entry out, one per cycle, until a slot is free
        ctrl.op   = lkv_pkg::CELL_DROP;
        count_nxt = count_r - CW'(1);
        if (count_ext <= eff_cap) begin
          state_nxt = lkv_pkg::ST_APPEND;
        end
      end
      lkv_pkg::ST_APPEND: begin
        ctrl.op   = lkv_pkg::CELL_APPEND;
        count_nxt = count_r + CW'(1);
        in_stall  = 1'b0;
        state_nxt = in_valid ? lkv_pkg::ST_CMP : lkv_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lkv_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lkv_pkg::ST_IDLE;
      count_r     <= '0;
      cap_r       <= lkv_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_kind;
      key_r   <= in_key;
      value_r <= in_value;
    end
    if (out_load) begin
      out_hit_r        <= hit;
      out_read_value_r <= hit ? sel_value : lkv_pkg::MISS_VALUE;
    end
  end

  genvar j;
  generate
    for (j = 0; j < MAX_ENTRIES; j++) begin : g_cell
      logic signed [31:0] up_key_w, up_value_w;
      logic               up_valid_w, lo_valid_w, pfx_in_w;

      if (j == MAX_ENTRIES - 1) begin : g_top
        assign up_key_w   = '0;
        assign up_value_w = '0;
        assign up_valid_w = 1'b0;
      end else begin : g_mid
        assign up_key_w   = cell_key[j+1];
        assign up_value_w = cell_value[j+1];
        assign up_valid_w = valid_vec[j+1];
      end

      if (j == 0) begin : g_bottom
        assign lo_valid_w = 1'b1;
        assign pfx_in_w   = 1'b0;
      end else begin : g_upper
        assign lo_valid_w = valid_vec[j-1];
        assign pfx_in_w   = pfx_vec[j-1];
      end

      lkv_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .up_key     (up_key_w),
        .up_value   (up_value_w),
        .up_valid   (up_valid_w),
        .lo_valid   (lo_valid_w),
        .pfx_in     (pfx_in_w),
        .slot_key   (cell_key[j]),
        .slot_value (cell_value[j]),
        .slot_valid (valid_vec[j]),
        .match      (match_vec[j]),
        .pfx_out    (pfx_vec[j])
      );
    end
  endgenerate

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_read_value_r;

  `LKV_ASSERT_IMPL(a_count_matches_valid, 1'b1, $countones(valid_vec) == CW'(count_r))
  `LKV_ASSERT_IMPL(a_valid_packed, 1'b1, (valid_vec & (valid_vec + MAX_ENTRIES'(1))) == '0)
  `LKV_ASSERT_IMPL(a_single_match, state_r == lkv_pkg::ST_ACT, $onehot0(match_vec))
  `LKV_ASSERT_IMPL(a_chain_hit, state_r == lkv_pkg::ST_ACT, hit == pfx_vec[MAX_ENTRIES-1])
  `LKV_ASSERT_IMPL(a_drop_only_full, state_r == lkv_pkg::ST_DROP, count_ext >= eff_cap)
  `LKV_ASSERT_NEXT(a_get_gives_beat, out_load, out_valid_r)

endmodule

// ----- tb/sv/tb_lru_key_value_cache.sv -----
// Self-checking testbench for lru_key_value_cache: directed and random gets and puts
// over several capacities, checked against a recency-ordered shadow of the cache.
// Depends on lkv_pkg and the lru_key_value_cache RTL.
`timescale 1ns / 100ps

module tb_lru_key_value_cache;

  localparam int SLOTS        = 16;
  localparam int POOL_SIZE    = 25;
  localparam int PHASE_ITEMS  = 122;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic signed [31:0] KEY_MIN = 32'sh80000000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFFFFFF;

  typedef struct {
    logic               kind;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } cache_op_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] value;
  } lookup_t;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               cfg_wr_en      = 1'b0;
  logic [4:0]         cfg_wr_data    = '0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic               in_kind        = lkv_pkg::KIND_GET;
  logic signed [31:0] in_key         = '0;
  logic signed [31:0] in_value       = '0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic               out_hit;
  logic signed [31:0] out_read_value;

  // shadow of the cache contents, slot 0 least recent
  logic signed [31:0] shadow_key   [SLOTS];
  logic signed [31:0] shadow_value [SLOTS];
  int                 shadow_count = 0;
  logic [4:0]         shadow_cap   = lkv_pkg::CAP_RESET;

  cache_op_t          queued_ops [$];
  lookup_t            pending_lookups [$];
  cache_op_t          next_op;
  lookup_t            expected_lookup;
  logic signed [31:0] key_pool [POOL_SIZE];

  logic in_taken      = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   error_count   = 0;
  int   cycle_count   = 0;

  lru_key_value_cache #(
    .MAX_ENTRIES(SLOTS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_key        (in_key),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_read_value(out_read_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one beat to the shadow; a get queues its expected lookup.
  task automatic lru_apply(input logic kind, input logic signed [31:0] key,
                           input logic signed [31:0] value);
    int                 pos;
    int                 cap;
    int                 n;
    int                 i;
    logic signed [31:0] k;
    logic signed [31:0] v;
    lookup_t            res;
    pos = -1;
    for (i = 0; i < shadow_count; i++)
      if (pos < 0 && shadow_key[i] == key) pos = i;
    if (pos >= 0) begin
      k = shadow_key[pos];
      v = shadow_value[pos];
      for (i = pos; i + 1 < shadow_count; i++) begin
        shadow_key[i]   = shadow_key[i + 1];
        shadow_value[i] = shadow_value[i + 1];
      end
      shadow_key[shadow_count - 1]   = k;
      shadow_value[shadow_count - 1] = v;
    end
    if (kind == lkv_pkg::KIND_GET) begin
      res.hit   = (pos >= 0);
      res.value = (pos >= 0) ? shadow_value[shadow_count - 1] : lkv_pkg::MISS_VALUE;
      pending_lookups.push_back(res);
    end else if (pos >= 0) begin
      shadow_value[shadow_count - 1] = value;
    end else begin
      cap = (shadow_cap == 0) ? 1 : (shadow_cap > SLOTS) ? SLOTS : int'(shadow_cap);
      // drop oldest until one slot is free below the capacity
      if (shadow_count >= cap) begin
        n = shadow_count - cap + 1;
        for (i = 0; i + n < shadow_count; i++) begin
          shadow_key[i]   = shadow_key[i + n];
          shadow_value[i] = shadow_value[i + n];
        end
        shadow_count -= n;
      end
      if (shadow_count < SLOTS) begin
        shadow_key[shadow_count]   = key;
        shadow_value[shadow_count] = value;
        shadow_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_count = 0;
      shadow_cap   = lkv_pkg::CAP_RESET;
      in_taken    <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (cfg_wr_en) shadow_cap = cfg_wr_data;
      if (in_valid && !in_stall) lru_apply(in_kind, in_key, in_value);
      if (out_valid && !out_stall) begin
        if (pending_lookups.size() == 0) begin
          $error("result beat with no lookup outstanding: hit=%0b read_value=%0d",
                 out_hit, out_read_value);
          error_count++;
        end else begin
          expected_lookup = pending_lookups.pop_front();
          if (out_hit !== expected_lookup.hit) begin
            $error("hit: expected %0b, got %0b", expected_lookup.hit, out_hit);
            error_count++;
          end
          if (out_read_value !== expected_lookup.value) begin
            $error("read_value: expected %0d, got %0d",
                   expected_lookup.value, out_read_value);
            error_count++;
          end
        end
      end
    end
  end

  // Drive on the falling edge; hold a beat until it has been taken.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    if (!in_valid || in_taken) begin
      if (queued_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_op = queued_ops.pop_front();
        in_valid <= 1'b1;
        in_kind  <= next_op.kind;
        in_key   <= next_op.key;
        in_value <= next_op.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic cache_op_t make_op(input logic kind, input logic signed [31:0] key,
                                        input logic signed [31:0] value);
    cache_op_t op;
    op.kind  = kind;
    op.key   = key;
    op.value = value;
    return op;
  endfunction

  // Keys mostly from a pool a little wider than the capacity, so hits and evictions mix.
  function automatic cache_op_t random_op(input int span);
    cache_op_t op;
    op.kind  = $urandom_range(0, 1) ? lkv_pkg::KIND_PUT : lkv_pkg::KIND_GET;
    op.key   = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, span - 1)];
    op.value = $urandom;
    return op;
  endfunction

  task automatic set_capacity(input logic [4:0] cap);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Wait for every beat to be taken and every lookup to return, then let puts settle.
  task automatic wait_idle();
    @(posedge clk);
    while (queued_ops.size() != 0 || in_valid) @(posedge clk);
    @(negedge clk);
    while (pending_lookups.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input int cap, input int s_idle, input int r_idle);
    int span;
    span = cap + cap / 2 + 1;
    set_capacity(cap[4:0]);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (PHASE_ITEMS) queued_ops.push_back(random_op(span));
    wait_idle();
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 31;
    recv_idle_pct = 76;

    // full capacity: empty miss, extreme keys and values, update on hit
    set_capacity(5'd16);
    queued_ops.push_back(make_op(lkv_pkg::KIND_GET, 32'sd0, 32'sd0));
    queued_ops.push_back(make_op(lkv_pkg::KIND_PUT, KEY_MIN, KEY_MAX));
    queued_ops.push_back(make_op(lkv_pkg::KIND_PUT, KEY_MAX, KEY_MIN));
    queued_ops.push_back(make_op(lkv_pkg::KIND_PUT, 32'sd0, 32'sd0));
    queued_ops.push_back(make_op(lkv_pkg::KIND_PUT, -32'sd1, -32'sd1));
    queued_ops.push_back(make_op(lkv_pkg::KIND_GET, KEY_MIN, 32'sd0));
    queued_ops.push_back(make_op(lkv_pkg::KIND_GET, -32'sd1, KEY_MAX));
    queued_ops.push_back(make_op(lkv_pkg::KIND_GET, 32'sd1, 32'sd0));
    queued_ops.push_back(make_op(lkv_pkg::KIND_PUT, 32'sd0, 32'sh5A5A5A5A));
    queued_ops.push_back(make_op(lkv_pkg::KIND_GET, 32'sd0, 32'sd0));
    queued_ops.push_back(make_op(lkv_pkg::KIND_GET, KEY_MAX, 32'sd0));
    wait_idle();

    // capacity lowered below the entry count: entries kept until a missing put
    set_capacity(5'd3);
    queued_ops.push_back(make_op(lkv_pkg::KIND_GET, KEY_MIN, 32'sd0));
    queued_ops.push_back(make_op(lkv_pkg::KIND_PUT, 32'sd7, 32'sd7));
    queued_ops.push_back(make_op(lkv_pkg::KIND_GET, KEY_MAX, 32'sd0));
    queued_ops.push_back(make_op(lkv_pkg::KIND_GET, -32'sd1, 32'sd0));
    wait_idle();

    // single entry: every missing put evicts
    set_capacity(5'd1);
    queued_ops.push_back(make_op(lkv_pkg::KIND_GET, 32'sd7, 32'sd0));
    queued_ops.push_back(make_op(lkv_pkg::KIND_PUT, 32'sd8, 32'sd8));
    queued_ops.push_back(make_op(lkv_pkg::KIND_GET, 32'sd7, 32'sd0));
    queued_ops.push_back(make_op(lkv_pkg::KIND_GET, 32'sd8, 32'sd0));
    queued_ops.push_back(make_op(lkv_pkg::KIND_PUT, 32'sd8, -32'sd8));
    queued_ops.push_back(make_op(lkv_pkg::KIND_GET, 32'sd8, 32'sd0));
    wait_idle();

    run_phase(16, 31, 76);
    run_phase(4, 31, 76);
    run_phase(1, 31, 76);
    run_phase(12, 76, 31);
    run_phase(16, 76, 31);
    run_phase(2, 76, 31);
    run_phase(8, 0, 0);
    run_phase(16, 0, 0);
    run_phase(5, 0, 0);

    if (error_count == 0 && pending_lookups.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/lkv_pkg.sv
rtl/core/lkv_cell.sv
rtl/core/lru_key_value_cache.sv
tb/sv/tb_lru_key_value_cache.sv
